[sv/rgb_gray_sobel_edge_assert.svh]
// Assertion macros used by the checker file.
`ifndef RGB_GRAY_SOBEL_EDGE_ASSERT_SVH
`define RGB_GRAY_SOBEL_EDGE_ASSERT_SVH

// Property checked only while out of reset.
`define RGBSE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked on every edge, reset included.
`define RGBSE_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[sv/rgbse_pkg.sv]
// ----------------------------------------------------------------------------
// rgbse_pkg
// Types and constants of the RGB to gray Sobel edge detector.
// ----------------------------------------------------------------------------
package rgbse_pkg;

    // Gray conversion weights
    localparam logic [7:0] GRAY_WEIGHT_RED   = 8'd77;
    localparam logic [7:0] GRAY_WEIGHT_GREEN = 8'd150;
    localparam logic [7:0] GRAY_WEIGHT_BLUE  = 8'd29;
    localparam logic [7:0] MAG_SATURATED     = 8'd255;

    // Configuration register indexes
    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    localparam int CFG_DATA_WIDTH = 13;
    localparam int MAX_HEIGHT     = 4096;

    // One window position sent from front to back
    typedef struct packed {
        logic [7:0]  p0;
        logic [7:0]  p1;
        logic [7:0]  p2;
        logic [7:0]  p3;
        logic [7:0]  p5;
        logic [7:0]  p6;
        logic [7:0]  p7;
        logic [7:0]  p8;
        logic [5:0]  pixel_column;
        logic [11:0] pixel_row;
        logic        frame_last;
    } window_entry_t;

    // Back end sequencer, one-hot
    typedef enum logic [4:0] {
        BK_IDLE = 5'b00001,
        BK_SQR  = 5'b00010,
        BK_ROOT = 5'b00100,
        BK_DONE = 5'b01000,
        BK_GRAD = 5'b10000
    } back_state_t;

endpackage

[sv/rgbse_pix_if.sv]
// ----------------------------------------------------------------------------
// rgbse_pix_if
// Pixel input channel. The edge result channel is rgbse_res_if, in its own file.
// ----------------------------------------------------------------------------
interface rgbse_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_start;

    modport source (output valid, red, green, blue, frame_start, input ready);
    modport sink   (input valid, red, green, blue, frame_start, output ready);
endinterface

[sv/rgbse_res_if.sv]
// ----------------------------------------------------------------------------
// rgbse_res_if
// Edge result channel.
// ----------------------------------------------------------------------------
interface rgbse_res_if;
    logic        valid;
    logic        ready;
    logic [5:0]  pixel_column;
    logic [11:0] pixel_row;
    logic [7:0]  edge_magnitude;
    logic        frame_last;

    modport source (output valid, pixel_column, pixel_row, edge_magnitude, frame_last,
                    input ready);
    modport sink   (input valid, pixel_column, pixel_row, edge_magnitude, frame_last,
                    output ready);
endinterface

[sv/rgbse_front.sv]
// ----------------------------------------------------------------------------
// rgbse_front
// Gray conversion, position counters, line stores and 3x3 window.
// ----------------------------------------------------------------------------
module rgbse_front #(
    parameter int MAX_WIDTH = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    rgbse_pix_if.sink                    pix,
    input  logic [6:0]                   image_width,
    input  logic [12:0]                  image_height,
    output logic                         q_valid,
    input  logic                         q_ready,
    output rgbse_pkg::window_entry_t     q_data
);
    import rgbse_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WW0 = $clog2(MAX_WIDTH + 1);
    localparam int WW  = (WW0 > 7) ? WW0 : 7;

    logic [CW-1:0] col_reg;
    logic [11:0]   row_reg;
    logic [CW-1:0] col_next;
    logic [11:0]   row_next;
    logic [CW-1:0] c_in;
    logic [11:0]   r_in;
    logic [WW-1:0] w_eff;
    logic [12:0]   h_eff;
    logic          accept;

    // Line stores
    logic [7:0] older_mem [MAX_WIDTH];
    logic [7:0] newer_mem [MAX_WIDTH];
    logic [7:0] older_rd_reg;
    logic [7:0] newer_rd_reg;

    // Second stage
    logic          b_valid_reg;
    logic [7:0]    b_gray_reg;
    logic [CW-1:0] b_col_reg;
    logic          b_interior_reg;
    logic [5:0]    b_out_col_reg;
    logic [11:0]   b_out_row_reg;
    logic          b_last_reg;
    logic          fwd_reg;
    logic [7:0]    fwd_top_reg;
    logic [7:0]    fwd_mid_reg;
    logic [7:0]    b_top;
    logic [7:0]    b_mid;
    logic          b_fire;

    logic [7:0] win_reg  [9];
    logic [7:0] win_next [9];

    logic [15:0] gray_sum;
    logic [7:0]  gray;

    // Effective sizes
    always_comb
    begin
        if (WW'(image_width) < WW'(3))
            w_eff = WW'(3);
        else if (WW'(image_width) > WW'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(image_width);
        if (image_height < 13'd3)
            h_eff = 13'd3;
        else if (image_height > 13'(MAX_HEIGHT))
            h_eff = 13'(MAX_HEIGHT);
        else
            h_eff = image_height;
    end

    assign c_in = pix.frame_start ? '0 : col_reg;
    assign r_in = pix.frame_start ? '0 : row_reg;

    assign b_fire    = b_valid_reg && (!b_interior_reg || q_ready);
    assign pix.ready = !b_valid_reg || b_fire;
    assign accept    = pix.valid && pix.ready;

    // Gray value
    assign gray_sum = 16'(pix.red) * 16'(GRAY_WEIGHT_RED)
                    + 16'(pix.green) * 16'(GRAY_WEIGHT_GREEN)
                    + 16'(pix.blue) * 16'(GRAY_WEIGHT_BLUE);
    assign gray = gray_sum[15:8];

    // Position counters wrap at row and frame end
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (WW'(c_in) + WW'(1) >= w_eff)
            begin
                col_next = '0;
                row_next = (13'(r_in) + 13'd1 >= h_eff) ? 12'd0 : r_in + 12'd1;
            end
            else
            begin
                col_next = c_in + CW'(1);
                row_next = r_in;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Read data with forwarding of the write in flight
    assign b_top = fwd_reg ? fwd_top_reg : older_rd_reg;
    assign b_mid = fwd_reg ? fwd_mid_reg : newer_rd_reg;

    // Line store memories
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            older_rd_reg <= older_mem[c_in];
            newer_rd_reg <= newer_mem[c_in];
        end
        if (b_fire)
        begin
            older_mem[b_col_reg] <= b_mid;
            newer_mem[b_col_reg] <= b_gray_reg;
        end
    end

    // Stage two control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (accept)
            b_valid_reg <= 1'b1;
        else if (b_fire)
            b_valid_reg <= 1'b0;
    end

    // Stage two payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_gray_reg     <= gray;
            b_col_reg      <= c_in;
            b_interior_reg <= (c_in >= CW'(2)) && (r_in >= 12'd2);
            b_out_col_reg  <= 6'(c_in - CW'(1));
            b_out_row_reg  <= r_in - 12'd1;
            b_last_reg     <= (WW'(c_in) == w_eff - WW'(1)) && (13'(r_in) == h_eff - 13'd1);
            fwd_reg        <= b_fire && (b_col_reg == c_in);
            fwd_top_reg    <= b_mid;
            fwd_mid_reg    <= b_gray_reg;
        end
    end

    // Window shift
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            win_next[k*3]     = win_reg[k*3+1];
            win_next[k*3 + 1] = win_reg[k*3+2];
        end
        win_next[2] = b_top;
        win_next[5] = b_mid;
        win_next[8] = b_gray_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 9; k++)
                win_reg[k] <= 8'd0;
        end
        else if (b_fire)
        begin
            for (int k = 0; k < 9; k++)
                win_reg[k] <= win_next[k];
        end
    end

    // Request to the queue
    assign q_valid = b_valid_reg && b_interior_reg;
    always_comb
    begin
        q_data.p0           = win_next[0];
        q_data.p1           = win_next[1];
        q_data.p2           = win_next[2];
        q_data.p3           = win_next[3];
        q_data.p5           = win_next[5];
        q_data.p6           = win_next[6];
        q_data.p7           = win_next[7];
        q_data.p8           = win_next[8];
        q_data.pixel_column = b_out_col_reg;
        q_data.pixel_row    = b_out_row_reg;
        q_data.frame_last   = b_last_reg;
    end

endmodule

[sv/rgbse_queue.sv]
// ----------------------------------------------------------------------------
// rgbse_queue
// Two-entry queue of window positions between front and back.
// ----------------------------------------------------------------------------
module rgbse_queue (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  rgbse_pkg::window_entry_t in_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output rgbse_pkg::window_entry_t out_data
);
    import rgbse_pkg::*;

    window_entry_t slot_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;
    logic          push;
    logic          pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= in_data;
    end

endmodule

[sv/rgbse_back.sv]
// ----------------------------------------------------------------------------
// rgbse_back
// Sobel gradients, gradient energy and bit-serial square root.
// ----------------------------------------------------------------------------
module rgbse_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     q_valid,
    output logic                     q_ready,
    input  rgbse_pkg::window_entry_t q_data,
    rgbse_res_if.source              res
);
    import rgbse_pkg::*;

    back_state_t state_reg;
    back_state_t state_next;

    logic signed [10:0] gx_reg;
    logic signed [10:0] gy_reg;
    logic [21:0]        energy_reg;
    logic [7:0]         root_reg;
    logic [2:0]         idx_reg;
    logic [5:0]         col_reg;
    logic [11:0]        row_reg;
    logic               last_reg;

    logic [10:0] sum_r;
    logic [10:0] sum_l;
    logic [10:0] sum_b;
    logic [10:0] sum_t;
    logic [7:0]  cand;
    logic [15:0] cand_sq;
    logic        pop;

    assign q_ready = (state_reg == BK_IDLE);
    assign pop     = q_valid && q_ready;

    // Column and row weighted sums
    assign sum_r = 11'(q_data.p2) + {2'b0, q_data.p5, 1'b0} + 11'(q_data.p8);
    assign sum_l = 11'(q_data.p0) + {2'b0, q_data.p3, 1'b0} + 11'(q_data.p6);
    assign sum_b = 11'(q_data.p6) + {2'b0, q_data.p7, 1'b0} + 11'(q_data.p8);
    assign sum_t = 11'(q_data.p0) + {2'b0, q_data.p1, 1'b0} + 11'(q_data.p2);

    // Root trial bit
    assign cand    = root_reg | (8'd1 << idx_reg);
    assign cand_sq = 16'(cand) * 16'(cand);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: if (q_valid) state_next = BK_GRAD;
            BK_GRAD: state_next = BK_SQR;
            BK_SQR:  state_next = BK_ROOT;
            BK_ROOT: if (idx_reg == 3'd0 || energy_reg[21:16] != 6'd0) state_next = BK_DONE;
            BK_DONE: if (res.ready) state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= BK_IDLE;
        else
            state_reg <= state_next;
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            BK_IDLE:
            begin
                if (pop)
                begin
                    gx_reg   <= $signed(sum_r - sum_l);
                    gy_reg   <= $signed(sum_b - sum_t);
                    col_reg  <= q_data.pixel_column;
                    row_reg  <= q_data.pixel_row;
                    last_reg <= q_data.frame_last;
                end
            end
            BK_GRAD:
            begin
                energy_reg <= 22'(gx_reg * gx_reg) + 22'(gy_reg * gy_reg);
            end
            BK_SQR:
            begin
                root_reg <= 8'd0;
                idx_reg  <= 3'd7;
            end
            BK_ROOT:
            begin
                if (energy_reg[21:16] != 6'd0)
                    root_reg <= MAG_SATURATED;
                else if (cand_sq <= energy_reg[15:0])
                    root_reg <= cand;
                idx_reg <= idx_reg - 3'd1;
            end
            default:
            begin
            end
        endcase
    end

    // Result channel
    assign res.valid          = (state_reg == BK_DONE);
    assign res.pixel_column   = col_reg;
    assign res.pixel_row      = row_reg;
    assign res.edge_magnitude = root_reg;
    assign res.frame_last     = last_reg;

endmodule

[sv/rgb_gray_sobel_edge.sv]
// ----------------------------------------------------------------------------
// rgb_gray_sobel_edge
// RGB to gray conversion and 3x3 Sobel edge magnitude over a pixel stream.
// ----------------------------------------------------------------------------
//  channel     | dir | request contents
//  ------------+-----+-----------------------------------------------
//  pixel_in    | in  | red, green, blue, frame_start
//  result_out  | out | pixel_column, pixel_row, edge_magnitude, frame_last
//  cfg_*       | in  | write enable, register index, data
//
//  Pixels are taken one per cycle while the two-entry window queue has room.
//  Each interior result passes through the back end steps in order (gradients,
//  energy, one set-up step, eight root steps, output), with a single root step
//  when the energy saturates; the bit-serial square root sets the result rate.
//  Reset clears counters, window, queue and sequencer; line stores are not
//  cleared. A stalled result_out holds the back end and then fills the queue.
// ----------------------------------------------------------------------------
module rgb_gray_sobel_edge #(
    parameter int MAX_WIDTH = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    rgbse_pix_if.sink                             pixel_in,
    rgbse_res_if.source                           result_out,
    input  logic                                  cfg_we,
    input  logic                                  cfg_index,
    input  logic [rgbse_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
    import rgbse_pkg::*;

    logic [6:0]    image_width_reg;
    logic [12:0]   image_height_reg;
    logic          fq_valid;
    logic          fq_ready;
    window_entry_t fq_data;
    logic          qb_valid;
    logic          qb_ready;
    window_entry_t qb_data;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= 7'd64;
            image_height_reg <= 13'd64;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[6:0];
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data[12:0];
                default:          image_width_reg  <= image_width_reg;
            endcase
        end
    end

    rgbse_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .pix          (pixel_in),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .q_valid      (fq_valid),
        .q_ready      (fq_ready),
        .q_data       (fq_data)
    );

    rgbse_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    rgbse_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (qb_valid),
        .q_ready (qb_ready),
        .q_data  (qb_data),
        .res     (result_out)
    );

endmodule

[sv/rgbse_checker.sv]
// ----------------------------------------------------------------------------
// rgbse_checker
// Port-level checks of the edge detector, bound to the top level.
// ----------------------------------------------------------------------------
`include "rgb_gray_sobel_edge_assert.svh"

module rgbse_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [5:0]  out_column,
    input logic [11:0] out_row,
    input logic [7:0]  out_magnitude
);
    // A stalled result keeps its magnitude and column
    `RGBSE_ASSERT(a_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_magnitude) && $stable(out_column), "result changed while stalled")
    // Results are interior pixels only
    `RGBSE_ASSERT(a_interior, clk, rst_n, out_valid |-> out_column != 6'd0 && out_row != 12'd0, "border pixel reported")
    // Results are never offered on consecutive cycles after a take
    `RGBSE_ASSERT(a_gap, clk, rst_n, out_valid && out_ready |=> !out_valid, "result repeated")
    // Nothing is offered straight out of reset
    `RGBSE_ASSERT_ALWAYS(a_reset, clk, !rst_n |=> !out_valid, "result offered after reset")
endmodule

bind rgb_gray_sobel_edge rgbse_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (result_out.valid),
    .out_ready     (result_out.ready),
    .out_column    (result_out.pixel_column),
    .out_row       (result_out.pixel_row),
    .out_magnitude (result_out.edge_magnitude)
);

[sim/rgb_gray_sobel_edge_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_gray_sobel_edge_test
// Self-checking bench for the RGB to gray Sobel edge detector. Pixel frames
// of many sizes are streamed in with random gaps on both channels. A
// behavioural copy of the gray conversion, line stores, window, gradient and
// saturating square root predicts each interior result, which is compared
// field by field with what the block returns.
// ----------------------------------------------------------------------------
module rgb_gray_sobel_edge_test;
    import rgbse_pkg::*;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_start;
        logic       drain_first;
    } pixel_req_t;

    typedef struct {
        logic [5:0]  pixel_column;
        logic [11:0] pixel_row;
        logic [7:0]  edge_magnitude;
        logic        frame_last;
    } edge_res_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_index;
    logic [CFG_DATA_WIDTH-1:0] cfg_data;

    rgbse_pix_if pix ();
    rgbse_res_if res ();

    rgb_gray_sobel_edge dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixel_in   (pix.sink),
        .result_out (res.source),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // Predictor state
    int unsigned width_reg;
    int unsigned height_reg;
    logic [7:0]  line_older [0:63];
    logic [7:0]  line_newer [0:63];
    logic [7:0]  win [0:8];
    int unsigned col_pos;
    int unsigned row_pos;

    pixel_req_t pixel_reqs [$];
    edge_res_t  edges_due [$];
    int         mismatches;
    int         results_seen;
    int         items_queued;
    bit         pix_taken;
    int         pix_gap;
    int         res_gap;
    int         hold_left;
    bit         hold_done;
    bit         quiet;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (quiet || roll < 70)
            return 0;
        else if (roll < 95)
            return $urandom_range(3, 1);
        else
            return $urandom_range(40, 10);
    endfunction

    function automatic logic [7:0] root_sat(int unsigned energy);
        logic [7:0] acc;
        logic [7:0] cand;
        acc = 8'd0;
        if (energy >= 65536)
            return MAG_SATURATED;
        for (int b = 7; b >= 0; b--)
        begin
            cand = acc | (8'd1 << b);
            if (int'(cand) * int'(cand) <= energy)
                acc = cand;
        end
        return acc;
    endfunction

    // Advance the predictor by one accepted pixel request
    task automatic predict_pixel(input pixel_req_t req);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        logic [7:0]  gray;
        logic [7:0]  top;
        logic [7:0]  mid;
        int          gx;
        int          gy;
        edge_res_t   e;
        w = (width_reg < 3) ? 3 : (width_reg > 64) ? 64 : width_reg;
        h = (height_reg < 3) ? 3 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
        if (req.frame_start)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        c = col_pos;
        r = row_pos;
        gray = 8'((32'd77 * req.red + 32'd150 * req.green + 32'd29 * req.blue) >> 8);
        top = line_older[c];
        mid = line_newer[c];
        line_older[c] = mid;
        line_newer[c] = gray;
        for (int k = 0; k < 3; k++)
        begin
            win[k*3]   = win[k*3+1];
            win[k*3+1] = win[k*3+2];
        end
        win[2] = top;
        win[5] = mid;
        win[8] = gray;
        if (c >= 2 && r >= 2)
        begin
            gx = (int'(win[2]) + 2*int'(win[5]) + int'(win[8]))
               - (int'(win[0]) + 2*int'(win[3]) + int'(win[6]));
            gy = (int'(win[6]) + 2*int'(win[7]) + int'(win[8]))
               - (int'(win[0]) + 2*int'(win[1]) + int'(win[2]));
            e.pixel_column   = 6'(c - 1);
            e.pixel_row      = 12'(r - 1);
            e.edge_magnitude = root_sat(gx*gx + gy*gy);
            e.frame_last     = (c == w - 1 && r == h - 1);
            edges_due.push_back(e);
        end
        if (c + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end
        else
            col_pos = c + 1;
    endtask

    // Input side: accepted requests feed the predictor
    always @(posedge clk)
    begin
        if (rst_n && pix.valid && pix.ready)
        begin
            pix_taken = 1'b1;
            predict_pixel('{pix.red, pix.green, pix.blue, pix.frame_start, 1'b0});
        end
    end

    // Pixel driver
    always @(negedge clk)
    begin
        pixel_req_t req;
        if (rst_n && !(pix.valid && !pix_taken))
        begin
            pix_taken = 1'b0;
            if (pix_gap > 0)
            begin
                pix_gap--;
                pix.valid <= 1'b0;
            end
            else if (pixel_reqs.size() > 0
                     && !(pixel_reqs[0].drain_first && edges_due.size() > 0))
            begin
                req = pixel_reqs.pop_front();
                pix.valid       <= 1'b1;
                pix.red         <= req.red;
                pix.green       <= req.green;
                pix.blue        <= req.blue;
                pix.frame_start <= req.frame_start;
                pix_gap = pick_gap();
            end
            else
                pix.valid <= 1'b0;
        end
    end

    // Result ready, with one long hold-off to back the block up
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                res.ready <= 1'b0;
            end
            else if (!hold_done && results_seen >= 200)
            begin
                hold_done = 1'b1;
                hold_left = 300;
                res.ready <= 1'b0;
            end
            else if (res_gap > 0)
            begin
                res_gap--;
                res.ready <= 1'b0;
            end
            else
            begin
                res.ready <= 1'b1;
                res_gap = pick_gap();
            end
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        edge_res_t e;
        if (rst_n && res.valid && res.ready)
        begin
            results_seen++;
            if (edges_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result col %0d row %0d mag %0d last %0b",
                             res.pixel_column, res.pixel_row, res.edge_magnitude,
                             res.frame_last);
            end
            else
            begin
                e = edges_due.pop_front();
                if (res.pixel_column !== e.pixel_column || res.pixel_row !== e.pixel_row
                    || res.edge_magnitude !== e.edge_magnitude
                    || res.frame_last !== e.frame_last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp col %0d row %0d mag %0d last %0b,",
                                 e.pixel_column, e.pixel_row, e.edge_magnitude,
                                 e.frame_last,
                                 " got col %0d row %0d mag %0d last %0b",
                                 res.pixel_column, res.pixel_row, res.edge_magnitude,
                                 res.frame_last);
                end
            end
        end
    end

    task automatic push_pixel(input int r, input int g, input int b, input bit fs,
                              input bit drain);
        pixel_reqs.push_back('{8'(r), 8'(g), 8'(b), fs, drain});
        items_queued++;
    endtask

    task automatic push_random(input int count, input bit fs, input bit drain);
        for (int i = 0; i < count; i++)
            push_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255),
                       fs && i == 0, drain && i == 0);
    endtask

    // Wait until every request is in and every result out, then let the
    // back end finish any pixel that makes no result
    task automatic settle();
        while (pixel_reqs.size() > 0 || pix.valid || edges_due.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input int value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_WIDTH'(value);
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_IMAGE_WIDTH)
            width_reg = value & 32'h7F;
        else
            height_reg = value & 32'h1FFF;
    endtask

    task automatic set_size(input int w, input int h);
        settle();
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
    endtask

    // Stimulus
    initial
    begin
        int w;
        int h;
        int ew;
        int eh;
        int roll;
        width_reg = 64;
        height_reg = 64;
        col_pos = 0;
        row_pos = 0;
        for (int i = 0; i < 64; i++)
        begin
            line_older[i] = 8'd0;
            line_newer[i] = 8'd0;
        end
        for (int i = 0; i < 9; i++)
            win[i] = 8'd0;
        mismatches = 0;
        results_seen = 0;
        items_queued = 0;
        pix_taken = 1'b0;
        pix_gap = 0;
        res_gap = 0;
        hold_left = 0;
        hold_done = 1'b0;
        quiet = 1'b0;
        pix.valid = 1'b0;
        pix.red = 8'd0;
        pix.green = 8'd0;
        pix.blue = 8'd0;
        pix.frame_start = 1'b0;
        res.ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_IMAGE_WIDTH;
        cfg_data = '0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Full width frame first so both line stores are written everywhere
        set_size(64, 3);
        push_random(192, 1'b1, 1'b0);

        // Smallest frame: saturating edge, flat white, single colours
        set_size(3, 3);
        for (int i = 0; i < 9; i++)
            push_pixel(i % 3 == 0 ? 0 : 255, i % 3 == 0 ? 0 : 255,
                       i % 3 == 0 ? 0 : 255, i == 0, 1'b0);
        for (int i = 0; i < 9; i++)
            push_pixel(255, 255, 255, i == 0, 1'b0);
        // next frame follows by row wrap, no frame start
        for (int i = 0; i < 9; i++)
            push_pixel(i < 3 ? 255 : 0, i >= 3 && i < 6 ? 255 : 0, i >= 6 ? 255 : 0,
                       1'b0, 1'b0);

        // Random frames over many sizes
        while (items_queued < 1300)
        begin
            roll = $urandom_range(99);
            if (roll < 25)
                w = 3;
            else if (roll < 35)
                w = 64;
            else if (roll < 42)
                w = (roll % 2) ? $urandom_range(2) : 127;
            else
                w = $urandom_range(20, 4);
            roll = $urandom_range(99);
            h = (roll < 8) ? ((roll % 2) ? $urandom_range(2) : 8191)
                           : $urandom_range(8, 3);
            ew = (w < 3) ? 3 : (w > 64) ? 64 : w;
            eh = (h < 3) ? 3 : (h > 8) ? 8 : h;
            quiet = ($urandom_range(3) == 0);
            set_size(w, h);
            for (int f = $urandom_range(3, 1); f > 0; f--)
            begin
                roll = $urandom_range(9);
                if (roll < 7)
                    push_random(ew * eh, 1'b1, roll == 0);
                else if (roll < 9)
                    push_random($urandom_range(ew * eh - 1, 1), 1'b1, 1'b0);
                else
                    push_random(ew * eh, 1'b0, 1'b0);
            end
        end

        // Start of the tallest frame on the narrowest row
        quiet = 1'b1;
        set_size(3, 4096);
        push_random(3 * 100, 1'b1, 1'b0);
        quiet = 1'b0;
        set_size(5, 4);
        push_random(20, 1'b1, 1'b1);

        settle();
        if (mismatches == 0 && edges_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
